// ===== rtl/mlpu_pkg.sv =====
`default_nettype none

package mlpu_pkg;

  // default lattice length
  localparam int SITES_DEF = 10;

  // configuration register indexes
  localparam logic [1:0] CFG_STEP_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_SPACING       = 2'd1;
  localparam logic [1:0] CFG_KINETIC_SCALE = 2'd2;
  localparam logic [1:0] CFG_QUARTIC_COEF  = 2'd3;

  // configuration reset values
  localparam logic [14:0] STEP_WIDTH_RST    = 15'd2867;
  localparam logic [15:0] SPACING_RST       = 16'd32768;
  localparam logic [15:0] KINETIC_SCALE_RST = 16'd1024;
  localparam logic [15:0] QUARTIC_COEF_RST  = 16'd16384;

  // item operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // integer part of the action change at or above which exp(-dS) reads as zero
  localparam logic [3:0] EXP_INT_LIMIT = 4'd12;

  typedef struct packed {
    logic               operation;
    logic [3:0]         load_site;
    logic signed [15:0] load_value;
    logic [15:0]        step_random;
    logic [15:0]        accept_random;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         site_index;
    logic signed [15:0] new_position;
    logic               accepted;
    logic               sweep_end;
    logic [3:0]         accept_count;
  } out_item_t;

  // datapath step codes issued by the controller
  typedef enum logic [4:0] {
    ST_NONE,
    ST_CAPTURE,
    ST_LOAD,
    ST_END_RD,
    ST_END_WR,
    ST_RD_X,
    ST_RD_NB,
    ST_RD_PV,
    ST_XN,
    ST_DIFF,
    ST_KIN,
    ST_X4H,
    ST_X4L,
    ST_XN4H,
    ST_XN4L,
    ST_QX,
    ST_QXN,
    ST_PX,
    ST_PXN,
    ST_PS,
    ST_DS,
    ST_EXP1,
    ST_EXP2,
    ST_EXP3,
    ST_EXP4,
    ST_DEC,
    ST_EMIT
  } dp_step_t;

  typedef struct packed {
    dp_step_t step;
  } dp_cmd_t;

  typedef struct packed {
    logic is_load;
    logic at_end;
    logic out_free;
  } dp_status_t;

  // round(65536*exp(-m)), zero where the term no longer matters
  function automatic logic [16:0] exp_int(input logic [3:0] m);
    logic [16:0] v;
    case (m)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // round(65536*exp(-j/8))
  function automatic logic [16:0] exp_frac(input logic [2:0] j);
    logic [16:0] v;
    case (j)
      3'd0:    v = 17'd65536;
      3'd1:    v = 17'd57835;
      3'd2:    v = 17'd51039;
      3'd3:    v = 17'd45042;
      3'd4:    v = 17'd39750;
      3'd5:    v = 17'd35079;
      3'd6:    v = 17'd30957;
      default: v = 17'd27319;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/metropolis_lattice_path_update.sv =====
`default_nettype none

// Metropolis update engine for a closed lattice path of SITES positions
// (signed Q3.12). Each update transaction visits the current site, proposes a
// shifted position, forms the local change of the Euclidean action and keeps
// or rejects the shift; the transaction at the last site copies site 0 into it
// and closes the sweep. Load transactions write single positions (hot start);
// after reset all positions are zero. One transaction is handled at a time:
// an update has the controller step the single shared 42x22 multiplier
// through the proposal shift, the squares, the kinetic product, the quartic
// terms, the action scaling and the exp table products. The next transaction
// is accepted as soon as the result sits in the output register. Input is
// stalled during reset. Configuration writes are ready whenever reset is low
// and must be made while no transaction is in progress.
module metropolis_lattice_path_update #(
  parameter int SITES = mlpu_pkg::SITES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mlpu_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mlpu_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);

  mlpu_pkg::dp_cmd_t    cmd;
  mlpu_pkg::dp_status_t status;

  assign cfg_ready = !rst;

  mlpu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mlpu_dp #(
    .SITES (SITES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/mlpu_ram.sv =====
`default_nettype none

module mlpu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/mlpu_ctrl.sv =====
`default_nettype none

module mlpu_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire mlpu_pkg::dp_status_t status,
  output mlpu_pkg::dp_cmd_t         cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_BRANCH,
    S_END_WR,
    S_RD_NB,
    S_RD_PV,
    S_XN,
    S_DIFF,
    S_KIN,
    S_X4H,
    S_X4L,
    S_XN4H,
    S_XN4L,
    S_QX,
    S_QXN,
    S_PX,
    S_PXN,
    S_PS,
    S_DS,
    S_EXP1,
    S_EXP2,
    S_EXP3,
    S_EXP4,
    S_DEC,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  // one item in flight, input taken only when idle and out of reset
  assign in_stall = rst || (state != S_IDLE);

  // next state and datapath step
  always_comb begin
    state_next = state;
    cmd.step   = mlpu_pkg::ST_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.step   = mlpu_pkg::ST_CAPTURE;
          state_next = S_BRANCH;
        end
      end
      S_BRANCH: begin
        if (status.is_load) begin
          cmd.step   = mlpu_pkg::ST_LOAD;
          state_next = S_RESULT;
        end else if (status.at_end) begin
          cmd.step   = mlpu_pkg::ST_END_RD;
          state_next = S_END_WR;
        end else begin
          cmd.step   = mlpu_pkg::ST_RD_X;
          state_next = S_RD_NB;
        end
      end
      S_END_WR: begin
        cmd.step   = mlpu_pkg::ST_END_WR;
        state_next = S_RESULT;
      end
      S_RD_NB: begin
        cmd.step   = mlpu_pkg::ST_RD_NB;
        state_next = S_RD_PV;
      end
      S_RD_PV: begin
        cmd.step   = mlpu_pkg::ST_RD_PV;
        state_next = S_XN;
      end
      S_XN: begin
        cmd.step   = mlpu_pkg::ST_XN;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.step   = mlpu_pkg::ST_DIFF;
        state_next = S_KIN;
      end
      S_KIN: begin
        cmd.step   = mlpu_pkg::ST_KIN;
        state_next = S_X4H;
      end
      S_X4H: begin
        cmd.step   = mlpu_pkg::ST_X4H;
        state_next = S_X4L;
      end
      S_X4L: begin
        cmd.step   = mlpu_pkg::ST_X4L;
        state_next = S_XN4H;
      end
      S_XN4H: begin
        cmd.step   = mlpu_pkg::ST_XN4H;
        state_next = S_XN4L;
      end
      S_XN4L: begin
        cmd.step   = mlpu_pkg::ST_XN4L;
        state_next = S_QX;
      end
      S_QX: begin
        cmd.step   = mlpu_pkg::ST_QX;
        state_next = S_QXN;
      end
      S_QXN: begin
        cmd.step   = mlpu_pkg::ST_QXN;
        state_next = S_PX;
      end
      S_PX: begin
        cmd.step   = mlpu_pkg::ST_PX;
        state_next = S_PXN;
      end
      S_PXN: begin
        cmd.step   = mlpu_pkg::ST_PXN;
        state_next = S_PS;
      end
      S_PS: begin
        cmd.step   = mlpu_pkg::ST_PS;
        state_next = S_DS;
      end
      S_DS: begin
        cmd.step   = mlpu_pkg::ST_DS;
        state_next = S_EXP1;
      end
      S_EXP1: begin
        cmd.step   = mlpu_pkg::ST_EXP1;
        state_next = S_EXP2;
      end
      S_EXP2: begin
        cmd.step   = mlpu_pkg::ST_EXP2;
        state_next = S_EXP3;
      end
      S_EXP3: begin
        cmd.step   = mlpu_pkg::ST_EXP3;
        state_next = S_EXP4;
      end
      S_EXP4: begin
        cmd.step   = mlpu_pkg::ST_EXP4;
        state_next = S_DEC;
      end
      S_DEC: begin
        cmd.step   = mlpu_pkg::ST_DEC;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.step   = mlpu_pkg::ST_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mlpu_dp.sv =====
`default_nettype none

module mlpu_dp #(
  parameter int SITES = mlpu_pkg::SITES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mlpu_pkg::dp_cmd_t   cmd,
  output mlpu_pkg::dp_status_t     status,
  input  wire mlpu_pkg::in_item_t  in_data,
  input  wire logic                cfg_valid,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mlpu_pkg::out_item_t      out_data
);

  localparam int IW = (SITES > 1) ? $clog2(SITES) : 1;
  localparam logic [IW-1:0] LAST = IW'(SITES - 1);

  // configuration
  logic [14:0] step_width;
  logic [15:0] spacing;
  logic [15:0] kinetic_scale;
  logic [15:0] quartic_coef;

  // control state
  logic [IW-1:0]    ptr;
  logic [3:0]       cnt;
  logic [SITES-1:0] vbits;
  logic             rdv;

  // working registers
  mlpu_pkg::in_item_t  item;
  mlpu_pkg::out_item_t res;
  logic signed [15:0]  x, nb, pv, xn;
  logic signed [16:0]  dd;
  logic signed [19:0]  ss;
  logic [30:0]         x2, xn2;
  logic signed [36:0]  kd;
  logic [63:0]         acc;
  logic [36:0]         x4, xn4;
  logic signed [41:0]  kterm;
  logic [39:0]         px;
  logic signed [40:0]  pd;
  logic signed [43:0]  ds;
  logic [16:0]         p1;
  logic [24:0]         g;
  logic signed [63:0]  mul_q;

  // memory ports and multiplier operands
  logic               we;
  logic [IW-1:0]      waddr;
  logic signed [15:0] wdata;
  logic [IW-1:0]      raddr;
  logic [15:0]        ram_rd;
  logic signed [41:0] ma;
  logic signed [21:0] mb;

  // derived values
  logic signed [15:0] rdx;
  logic signed [17:0] r2;
  logic signed [17:0] rho;
  logic signed [17:0] xsum;
  logic signed [15:0] xsat;
  logic signed [19:0] ss_one, ss_two;
  logic [63:0]        sum4;
  logic               big;
  logic [16:0]        pdec;
  logic               take;
  logic               load_ok;
  logic [3:0]         cnt_inc;

  mlpu_ram #(
    .WIDTH (16),
    .DEPTH (SITES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_rd)
  );

  // never-written sites read as zero
  assign rdx = rdv ? $signed(ram_rd) : 16'sd0;

  // proposal shift and saturated position
  assign r2   = $signed({1'b0, item.step_random, 1'b0}) - 18'sd65536;
  assign rho  = $signed(mul_q[33:16]);
  assign xsum = 18'(x) + rho;
  always_comb begin
    if (xsum > 18'sd32767) begin
      xsat = 16'sh7FFF;
    end else if (xsum < -18'sd32768) begin
      xsat = 16'sh8000;
    end else begin
      xsat = xsum[15:0];
    end
  end

  // kinetic change is (x - xn) times this sum
  assign ss_one = (20'(nb) <<< 1) - 20'(xn) - 20'(x);
  assign ss_two = (20'(nb) + 20'(pv) - 20'(xn) - 20'(x)) <<< 1;

  assign sum4 = acc + $unsigned(mul_q);

  // acceptance test
  assign big     = (ds[43:28] != '0) || (ds[27:24] >= mlpu_pkg::EXP_INT_LIMIT);
  assign pdec    = mul_q[40:24];
  assign take    = (ds <= 44'sd0) ||
                   ({1'b0, item.accept_random} <= (big ? 17'd0 : pdec));
  assign load_ok = {1'b0, item.load_site} < 5'(SITES);
  assign cnt_inc = (cnt == 4'hF) ? cnt : cnt + 4'd1;

  assign status.is_load  = (item.operation == mlpu_pkg::OP_LOAD);
  assign status.at_end   = (ptr == LAST);
  assign status.out_free = !out_valid || !out_stall;

  // memory access and multiplier operand select per step
  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    ma    = '0;
    mb    = '0;
    unique case (cmd.step)
      mlpu_pkg::ST_END_WR: begin
        we    = 1'b1;
        waddr = LAST;
        wdata = rdx;
      end
      mlpu_pkg::ST_LOAD: begin
        we    = load_ok;
        waddr = item.load_site[IW-1:0];
        wdata = item.load_value;
      end
      mlpu_pkg::ST_RD_X: begin
        raddr = ptr;
      end
      mlpu_pkg::ST_RD_NB: begin
        raddr = ptr + IW'(1);
      end
      mlpu_pkg::ST_RD_PV: begin
        raddr = (ptr == '0) ? '0 : ptr - IW'(1);
        ma    = 42'(r2);
        mb    = 22'(step_width);
      end
      mlpu_pkg::ST_XN: begin
        ma = 42'(x);
        mb = 22'(x);
      end
      mlpu_pkg::ST_DIFF: begin
        ma = 42'(xn);
        mb = 22'(xn);
      end
      mlpu_pkg::ST_KIN: begin
        ma = 42'(ss);
        mb = 22'(dd);
      end
      mlpu_pkg::ST_X4H: begin
        ma = 42'(x2);
        mb = 22'(x2[30:15]);
      end
      mlpu_pkg::ST_X4L: begin
        ma = 42'(x2);
        mb = 22'(x2[14:0]);
      end
      mlpu_pkg::ST_XN4H: begin
        ma = 42'(xn2);
        mb = 22'(xn2[30:15]);
      end
      mlpu_pkg::ST_XN4L: begin
        ma = 42'(xn2);
        mb = 22'(xn2[14:0]);
      end
      mlpu_pkg::ST_QX: begin
        ma = 42'(kd);
        mb = 22'(kinetic_scale);
      end
      mlpu_pkg::ST_QXN: begin
        ma = 42'(x4);
        mb = 22'(quartic_coef);
      end
      mlpu_pkg::ST_PX: begin
        ma = 42'(xn4);
        mb = 22'(quartic_coef);
      end
      mlpu_pkg::ST_PS: begin
        ma = 42'(pd);
        mb = 22'(spacing);
      end
      mlpu_pkg::ST_EXP1: begin
        ma = 42'(mlpu_pkg::exp_int(ds[27:24]));
        mb = 22'(mlpu_pkg::exp_frac(ds[23:21]));
      end
      mlpu_pkg::ST_EXP2: begin
        ma = 42'(ds[20:0]);
        mb = 22'(ds[20:0]);
      end
      mlpu_pkg::ST_EXP4: begin
        ma = 42'(g);
        mb = 22'(p1);
      end
      mlpu_pkg::ST_DEC: begin
        we    = take;
        waddr = ptr;
        wdata = xn;
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_width    <= mlpu_pkg::STEP_WIDTH_RST;
      spacing       <= mlpu_pkg::SPACING_RST;
      kinetic_scale <= mlpu_pkg::KINETIC_SCALE_RST;
      quartic_coef  <= mlpu_pkg::QUARTIC_COEF_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mlpu_pkg::CFG_STEP_WIDTH:    step_width    <= cfg_data[14:0];
        mlpu_pkg::CFG_SPACING:       spacing       <= cfg_data;
        mlpu_pkg::CFG_KINETIC_SCALE: kinetic_scale <= cfg_data;
        mlpu_pkg::CFG_QUARTIC_COEF:  quartic_coef  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sweep pointer, accept counter, site valid bits, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      cnt       <= '0;
      vbits     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (we) begin
        vbits[waddr] <= 1'b1;
      end
      if (cmd.step == mlpu_pkg::ST_END_WR) begin
        ptr <= '0;
        cnt <= '0;
      end else if (cmd.step == mlpu_pkg::ST_DEC) begin
        ptr <= ptr + IW'(1);
        if (take) begin
          cnt <= cnt_inc;
        end
      end
      if (cmd.step == mlpu_pkg::ST_EMIT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    mul_q <= ma * mb;
    rdv   <= vbits[raddr];
  end

  // working registers loaded per step
  always_ff @(posedge clk) begin
    case (cmd.step)
      mlpu_pkg::ST_CAPTURE: item <= in_data;
      mlpu_pkg::ST_RD_NB:   x    <= rdx;
      mlpu_pkg::ST_RD_PV:   nb   <= rdx;
      mlpu_pkg::ST_XN: begin
        pv <= (ptr == '0) ? 16'sd0 : rdx;
        xn <= xsat;
      end
      mlpu_pkg::ST_DIFF: begin
        x2 <= mul_q[30:0];
        dd <= 17'(x) - 17'(xn);
        ss <= (ptr == '0) ? ss_one : ss_two;
      end
      mlpu_pkg::ST_KIN:   xn2   <= mul_q[30:0];
      mlpu_pkg::ST_X4H:   kd    <= $signed(mul_q[36:0]);
      mlpu_pkg::ST_X4L:   acc   <= {mul_q[48:0], 15'd0};
      mlpu_pkg::ST_XN4H:  x4    <= sum4[60:24];
      mlpu_pkg::ST_XN4L:  acc   <= {mul_q[48:0], 15'd0};
      mlpu_pkg::ST_QX:    xn4   <= sum4[60:24];
      mlpu_pkg::ST_QXN:   kterm <= $signed(mul_q[53:12]);
      mlpu_pkg::ST_PX:    px    <= 40'(x2[30:1]) + 40'(mul_q[52:14]);
      mlpu_pkg::ST_PXN: begin
        pd <= $signed(41'(xn2[30:1]) + 41'(mul_q[52:14])) - $signed({1'b0, px});
      end
      mlpu_pkg::ST_DS:    ds    <= 44'(kterm) + $signed(mul_q[58:15]);
      mlpu_pkg::ST_EXP2:  p1    <= mul_q[32:16];
      mlpu_pkg::ST_EXP3: begin
        g <= 25'd16777216 - 25'(ds[20:0]) + 25'(mul_q[41:25]);
      end
      mlpu_pkg::ST_LOAD: begin
        res.site_index   <= item.load_site;
        res.new_position <= load_ok ? item.load_value : 16'sd0;
        res.accepted     <= 1'b0;
        res.sweep_end    <= 1'b0;
        res.accept_count <= cnt;
      end
      mlpu_pkg::ST_END_WR: begin
        res.site_index   <= 4'(SITES - 1);
        res.new_position <= rdx;
        res.accepted     <= 1'b0;
        res.sweep_end    <= 1'b1;
        res.accept_count <= cnt;
      end
      mlpu_pkg::ST_DEC: begin
        res.site_index   <= 4'(ptr);
        res.new_position <= take ? xn : x;
        res.accepted     <= take;
        res.sweep_end    <= 1'b0;
        res.accept_count <= take ? cnt_inc : cnt;
      end
      default: begin
      end
    endcase
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.step == mlpu_pkg::ST_EMIT) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mlpu_props.sv =====
`default_nettype none

module mlpu_props (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire mlpu_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire mlpu_pkg::out_item_t out_data
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // one transaction in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a transaction is in work");

  // a kept proposal is counted, a sweep end never keeps one
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.accepted |->
      (out_data.accept_count != 4'd0) && !out_data.sweep_end)
    else $error("accepted result with zero count or at sweep end");

endmodule

bind metropolis_lattice_path_update mlpu_props u_props (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ===== bench/tb_metropolis_lattice_path_update.sv =====
`default_nettype none

module tb_metropolis_lattice_path_update;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSITES = mlpu_pkg::SITES_DEF;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  mlpu_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  mlpu_pkg::out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  metropolis_lattice_path_update #(.SITES(NSITES)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic signed [15:0] path_pos [NSITES];
  int unsigned visit_ptr;
  int unsigned kept_count;
  logic [14:0] eps_reg;
  logic [15:0] spacing_reg;
  logic [15:0] kin_reg;
  logic [15:0] lambda_reg;

  mlpu_pkg::out_item_t expected_sites[$];
  int errors;
  int results_seen;
  int updates_sent;
  int loads_sent;
  longint cycles = 0;
  int send_idle_pct;
  int recv_stall_pct;

  // directed stimulus table with optional typed-in result
  typedef struct {
    mlpu_pkg::in_item_t item;
    bit has_fixed;
    mlpu_pkg::out_item_t fixed;
  } dir_row_t;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic longint fdiv(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint potential_of(longint x);
    longint x2;
    longint x4;
    x2 = x * x;
    x4 = (x2 * x2) >>> 24;
    return (x2 >>> 1) + ((longint'(lambda_reg) * x4) >>> 14);
  endfunction

  function automatic longint exp_int_tab(int m);
    longint t[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
    return t[m];
  endfunction

  function automatic longint exp_frac_tab(int j);
    longint t[8] = '{65536, 57835, 51039, 45042, 39750, 35079, 30957, 27319};
    return t[j];
  endfunction

  function automatic longint boltzmann_weight(longint c);
    longint m;
    longint j;
    longint r;
    longint g;
    longint p;
    m = c >>> 24;
    if (m >= 12) return 0;
    j = (c >>> 21) & 7;
    r = c & 64'h1FFFFF;
    p = (exp_int_tab(int'(m)) * exp_frac_tab(int'(j))) >>> 16;
    g = (64'd1 << 24) - r + ((r * r) >>> 25);
    return (p * g) >>> 24;
  endfunction

  // advance the lattice model by one transaction
  function automatic mlpu_pkg::out_item_t predict_site(mlpu_pkg::in_item_t it);
    mlpu_pkg::out_item_t o;
    longint x, xn, rho, nb, pv, d0, d1, kd, ds;
    bit keep;
    o = '0;
    o.site_index = 4'(visit_ptr);
    if (it.operation == mlpu_pkg::OP_LOAD) begin
      o.site_index = it.load_site;
      if (it.load_site < NSITES) begin
        path_pos[it.load_site] = it.load_value;
        o.new_position = it.load_value;
      end
      o.accept_count = 4'(kept_count);
    end else if (visit_ptr >= NSITES - 1) begin
      path_pos[NSITES-1] = path_pos[0];
      o.site_index = 4'(NSITES - 1);
      o.new_position = path_pos[0];
      o.sweep_end = 1'b1;
      o.accept_count = 4'(kept_count);
      visit_ptr = 0;
      kept_count = 0;
    end else begin
      x = path_pos[visit_ptr];
      rho = fdiv(longint'(eps_reg) * (2 * longint'(it.step_random) - 65536), 16);
      xn = x + rho;
      if (xn > 32767) xn = 32767;
      if (xn < -32768) xn = -32768;
      nb = path_pos[visit_ptr+1];
      d1 = nb - xn;
      d0 = nb - x;
      kd = d1 * d1 - d0 * d0;
      if (visit_ptr > 0) begin
        pv = path_pos[visit_ptr-1];
        d1 = xn - pv;
        d0 = x - pv;
        kd += d1 * d1 - d0 * d0;
      end
      ds = fdiv(kd * longint'(kin_reg), 12)
         + fdiv((potential_of(xn) - potential_of(x)) * longint'(spacing_reg), 15);
      keep = (ds <= 0) || (longint'(it.accept_random) <= boltzmann_weight(ds));
      if (keep) begin
        path_pos[visit_ptr] = 16'(xn);
        if (kept_count < 15) kept_count++;
      end
      o.new_position = path_pos[visit_ptr];
      o.accepted = keep;
      o.accept_count = 4'(kept_count);
      visit_ptr++;
    end
    return o;
  endfunction

  // one line per mismatch, and count it
  task automatic report_mismatch(string msg);
    errors++;
    $display("mismatch %s (result %0d)", msg, results_seen);
  endtask

  // result checker
  always @(posedge clk) begin
    mlpu_pkg::out_item_t w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_sites.size() == 0) begin
        report_mismatch($sformatf("unexpected result transaction at site %0d",
                                  out_data.site_index));
      end else begin
        w = expected_sites.pop_front();
        if (out_data.site_index !== w.site_index)
          report_mismatch($sformatf("site_index: got %0d expected %0d",
                                    out_data.site_index, w.site_index));
        if (out_data.new_position !== w.new_position)
          report_mismatch($sformatf("new_position: got %0d expected %0d",
                                    out_data.new_position, w.new_position));
        if (out_data.accepted !== w.accepted)
          report_mismatch($sformatf("accepted: got %0d expected %0d",
                                    out_data.accepted, w.accepted));
        if (out_data.sweep_end !== w.sweep_end)
          report_mismatch($sformatf("sweep_end: got %0d expected %0d",
                                    out_data.sweep_end, w.sweep_end));
        if (out_data.accept_count !== w.accept_count)
          report_mismatch($sformatf("accept_count: got %0d expected %0d",
                                    out_data.accept_count, w.accept_count));
      end
      results_seen++;
    end
  end

  // receiver stall
  always @(negedge clk) begin
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_site(mlpu_pkg::in_item_t it, bit has_fixed,
                           mlpu_pkg::out_item_t fixed);
    mlpu_pkg::out_item_t p;
    while ((send_idle_pct > 0) && ($urandom_range(99) < send_idle_pct))
      @(negedge clk);
    in_data = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_site(it);
    if (has_fixed && p !== fixed)
      report_mismatch($sformatf("directed row disagrees with predictor at site %0d",
                                p.site_index));
    expected_sites.push_back(p);
    if (it.operation == mlpu_pkg::OP_LOAD) loads_sent++;
    else updates_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_sites.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      mlpu_pkg::CFG_STEP_WIDTH:    eps_reg = val[14:0];
      mlpu_pkg::CFG_SPACING:       spacing_reg = val;
      mlpu_pkg::CFG_KINETIC_SCALE: kin_reg = val;
      mlpu_pkg::CFG_QUARTIC_COEF:  lambda_reg = val;
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic mlpu_pkg::in_item_t rand_item(int load_pct);
    mlpu_pkg::in_item_t it;
    it.operation = ($urandom_range(99) < load_pct) ? mlpu_pkg::OP_LOAD
                                                    : mlpu_pkg::OP_UPDATE;
    it.load_site = 4'($urandom_range(15));
    it.load_value = 16'($urandom);
    // loads mostly small so the path stays in a physical range
    if ($urandom_range(3) != 0) it.load_value = 16'($signed($urandom_range(16383)) - 8192);
    it.step_random = 16'($urandom);
    it.accept_random = 16'($urandom);
    return it;
  endfunction

  task automatic run_phase(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n; k++)
      send_site(rand_item(($urandom_range(9) == 0) ? 60 : 6), 1'b0, '0);
  endtask

  function automatic mlpu_pkg::in_item_t mk(logic op, int site, int val, int sr, int ar);
    mlpu_pkg::in_item_t it;
    it.operation = op;
    it.load_site = 4'(site);
    it.load_value = 16'(val);
    it.step_random = 16'(sr);
    it.accept_random = 16'(ar);
    return it;
  endfunction

  function automatic mlpu_pkg::out_item_t res(int site, int pos, bit acc, bit se, int cnt);
    mlpu_pkg::out_item_t o;
    o.site_index = 4'(site);
    o.new_position = 16'(pos);
    o.accepted = acc;
    o.sweep_end = se;
    o.accept_count = 4'(cnt);
    return o;
  endfunction

  initial begin
    dir_row_t rows[$];
    logic [15:0] cfg_set [4][4];
    errors = 0;
    results_seen = 0;
    updates_sent = 0;
    loads_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = mlpu_pkg::CFG_STEP_WIDTH;
    cfg_data = '0;
    for (int k = 0; k < NSITES; k++) path_pos[k] = '0;
    visit_ptr = 0;
    kept_count = 0;
    eps_reg = mlpu_pkg::STEP_WIDTH_RST;
    spacing_reg = mlpu_pkg::SPACING_RST;
    kin_reg = mlpu_pkg::KINETIC_SCALE_RST;
    lambda_reg = mlpu_pkg::QUARTIC_COEF_RST;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: cold-start update with zero shift, loads, extremes, sweep end
    rows.push_back('{mk(mlpu_pkg::OP_UPDATE, 0, 0, 32768, 65535), 1, res(0, 0, 1, 0, 1)});
    rows.push_back('{mk(mlpu_pkg::OP_LOAD, 3, 32767, 0, 0), 1, res(3, 32767, 0, 0, 1)});
    rows.push_back('{mk(mlpu_pkg::OP_LOAD, 4, -32768, 65535, 65535), 1,
                     res(4, -32768, 0, 0, 1)});
    rows.push_back('{mk(mlpu_pkg::OP_LOAD, 15, 1234, 0, 0), 1, res(15, 0, 0, 0, 1)});
    rows.push_back('{mk(mlpu_pkg::OP_LOAD, 10, -1, 0, 0), 1, res(10, 0, 0, 0, 1)});
    rows.push_back('{mk(mlpu_pkg::OP_UPDATE, 0, 0, 65535, 0), 0, '0});
    rows.push_back('{mk(mlpu_pkg::OP_UPDATE, 0, 0, 0, 65535), 0, '0});
    rows.push_back('{mk(mlpu_pkg::OP_UPDATE, 0, 0, 65535, 65535), 0, '0});
    rows.push_back('{mk(mlpu_pkg::OP_UPDATE, 0, 0, 0, 0), 0, '0});
    for (int k = 0; k < 5; k++)
      rows.push_back('{mk(mlpu_pkg::OP_UPDATE, 0, 0, $urandom, $urandom), 0, '0});
    rows.push_back('{mk(mlpu_pkg::OP_UPDATE, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(mlpu_pkg::OP_UPDATE, 0, 0, 1, 1), 0, '0});
    rows.push_back('{mk(mlpu_pkg::OP_LOAD, 0, 32767, 0, 0), 0, '0});
    rows.push_back('{mk(mlpu_pkg::OP_UPDATE, 0, 0, 65535, 0), 0, '0});
    foreach (rows[k]) send_site(rows[k].item, rows[k].has_fixed, rows[k].fixed);
    wait_drained();

    // register settings: defaults-like, minimum, maximum but for spacing, wide step
    cfg_set[0] = '{16'd2867, 16'd32768, 16'd1024, 16'd16384};
    cfg_set[1] = '{16'd0, 16'd0, 16'd0, 16'd0};
    cfg_set[2] = '{16'h7FFF, 16'd32768, 16'hFFFF, 16'hFFFF};
    cfg_set[3] = '{16'd12000, 16'd16384, 16'd2048, 16'd4096};

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_reg(mlpu_pkg::CFG_STEP_WIDTH, cfg_set[ph][0]);
      write_reg(mlpu_pkg::CFG_SPACING, cfg_set[ph][1]);
      write_reg(mlpu_pkg::CFG_KINETIC_SCALE, cfg_set[ph][2]);
      write_reg(mlpu_pkg::CFG_QUARTIC_COEF, cfg_set[ph][3]);
      run_phase(120, 0, 0);
      run_phase(110, 73, 0);
      run_phase(110, 0, 73);
      run_phase(122, 19, 19);
      recv_stall_pct = 0;
      wait_drained();
    end

    $display("covered %0d updates and %0d loads, %0d results, over 4 register settings",
             updates_sent, loads_sent, results_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== metropolis_lattice_path_update.f =====
rtl/mlpu_pkg.sv
rtl/mlpu_ram.sv
rtl/mlpu_ctrl.sv
rtl/mlpu_dp.sv
rtl/metropolis_lattice_path_update.sv
rtl/mlpu_props.sv
bench/tb_metropolis_lattice_path_update.sv
